### rtl/flb_pkg.sv
// ----------------------------------------------------------------------------
// flb_pkg: shared constants and types for the FIFO/LIFO byte buffer
// Store geometry, request and status codes, and the lane control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package flb_pkg;

    // Store geometry. STORE_BYTES is a power of two of at least 16 bytes.
    localparam int STORE_BYTES = 64;
    localparam int LANES       = 8;
    localparam int LANE_W      = $clog2(LANES);
    localparam int IDX_W       = $clog2(STORE_BYTES);
    localparam int ROW_W       = IDX_W - LANE_W;
    localparam int ROWS        = STORE_BYTES / LANES;
    localparam int FILL_W      = $clog2(STORE_BYTES + 1);

    // Field widths of the channels.
    localparam int BYTE_W     = 8;
    localparam int VALUE_W    = 64;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int FILL_OUT_W = 7;
    localparam int LOG_W      = 2;
    localparam int SIZE_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LOG  = 1'd1;

    // Control broadcast from the sequencer to every byte lane.
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ROW_W-1:0]  row;
        logic [LANE_W-1:0] offset;
        logic [LANE_W-1:0] mask;
        logic              stack;
    } t_lane_ctl;

    // What one lane returns after a read.
    typedef struct packed {
        logic              act;
        logic [LANE_W-1:0] pos;
        logic [BYTE_W-1:0] data;
    } t_lane_rd;

    // Value width in bytes for a given log2 width.
    function automatic logic [SIZE_W-1:0] log_to_bytes(input logic [LOG_W-1:0] log_w);
        log_to_bytes = SIZE_W'(1) << log_w;
    endfunction

endpackage

`default_nettype wire

### rtl/flb_req_if.sv
// ----------------------------------------------------------------------------
// flb_req_if: request channel of the byte buffer
// Valid/ready handshake carrying the request code and the push value.
// ----------------------------------------------------------------------------
`default_nettype none

interface flb_req_if;
    logic                          valid;
    logic                          ready;
    logic [flb_pkg::REQ_W-1:0]     req_type;
    logic [flb_pkg::VALUE_W-1:0]   push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

`default_nettype wire

### rtl/flb_rsp_if.sv
// ----------------------------------------------------------------------------
// flb_rsp_if: response channel of the byte buffer
// Valid/ready handshake carrying the popped value, status and fill level.
// ----------------------------------------------------------------------------
`default_nettype none

interface flb_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [flb_pkg::VALUE_W-1:0]     pop_value;
    logic [flb_pkg::STATUS_W-1:0]    status;
    logic [flb_pkg::FILL_OUT_W-1:0]  fill_bytes;

    modport source (output valid, output pop_value, output status, output fill_bytes,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input fill_bytes,
                    output ready);
endinterface

`default_nettype wire

### rtl/fifo_lifo_byte_buffer.sv
// ----------------------------------------------------------------------------
// fifo_lifo_byte_buffer: FIFO/LIFO ring buffer of 1, 2, 4 or 8 byte values
// A 64-byte ring split over eight byte lanes; a push or pop moves one whole
// value through the lanes in parallel and a merge stage rebuilds pop data.
//
//   Channel   Dir   Handshake            Beat contents
//   i_req     in    valid/ready          req_type, push_value
//   o_rsp     out   valid/ready          pop_value, status, fill_bytes
//   i_cfg_*   in    write enable only    register index, data
//
// A push, clear or rejected request has its result registered directly; a successful
// pop also passes through the registered read of the lane memories first.
// Reset is synchronous and active low and empties the store; store contents
// are not cleared. The output register lets the next beat be accepted in the
// cycle the current result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_lifo_byte_buffer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    flb_req_if.sink                                i_req,
    flb_rsp_if.source                              o_rsp,
    input  wire logic                              i_cfg_we,
    input  wire logic [flb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [flb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                              r_stack;
    logic [flb_pkg::LOG_W-1:0]         r_log;
    logic [flb_pkg::IDX_W-1:0]         r_wi;
    logic [flb_pkg::FILL_W-1:0]        r_held;
    logic                              r_busy;
    logic                              r_out_valid;
    logic [flb_pkg::VALUE_W-1:0]       r_pop_value;
    logic [flb_pkg::STATUS_W-1:0]      r_status;
    logic [flb_pkg::FILL_OUT_W-1:0]    r_fill;

    logic [flb_pkg::IDX_W-1:0]         n_wi;
    logic [flb_pkg::FILL_W-1:0]        n_held;
    logic [flb_pkg::STATUS_W-1:0]      status;
    logic                              acc;
    logic [flb_pkg::SIZE_W-1:0]        size;
    logic [flb_pkg::FILL_W:0]          push_sum;
    logic                              full;
    logic                              empty;
    logic [flb_pkg::IDX_W-1:0]         fifo_addr;
    logic [flb_pkg::IDX_W-1:0]         lifo_addr;
    logic [flb_pkg::IDX_W-1:0]         addr;
    logic                              wr;
    logic                              rd;
    flb_pkg::t_lane_ctl                lane_ctl;
    flb_pkg::t_lane_rd                 lane_rd [flb_pkg::LANES];
    logic [flb_pkg::VALUE_W-1:0]       merged;

    // A new beat is taken when no pop is in flight and the output can move.
    assign i_req.ready = !r_busy && (!r_out_valid || o_rsp.ready);
    assign acc         = i_req.valid && i_req.ready;

    // Occupancy checks and read positions.
    always_comb begin
        size      = flb_pkg::log_to_bytes(r_log);
        push_sum  = (flb_pkg::FILL_W+1)'(r_held) + (flb_pkg::FILL_W+1)'(size);
        full      = push_sum > (flb_pkg::FILL_W+1)'(flb_pkg::STORE_BYTES);
        empty     = r_held < flb_pkg::FILL_W'(size);
        fifo_addr = r_wi - flb_pkg::IDX_W'(r_held);
        lifo_addr = r_wi - flb_pkg::IDX_W'(size);
    end

    // Request decode: next pointers, status and lane strobes.
    always_comb begin
        n_wi   = r_wi;
        n_held = r_held;
        status = flb_pkg::ST_DONE;
        wr     = 1'b0;
        rd     = 1'b0;
        addr   = r_wi;
        case (i_req.req_type)
            flb_pkg::REQ_PUSH: begin
                if (full) begin
                    status = flb_pkg::ST_FULL;
                end else begin
                    wr     = acc;
                    n_wi   = r_wi + flb_pkg::IDX_W'(size);
                    n_held = r_held + flb_pkg::FILL_W'(size);
                end
            end
            flb_pkg::REQ_POP: begin
                if (empty) begin
                    status = flb_pkg::ST_EMPTY;
                end else begin
                    rd     = acc;
                    n_held = r_held - flb_pkg::FILL_W'(size);
                    if (r_stack) begin
                        addr = lifo_addr;
                        n_wi = lifo_addr;
                    end else begin
                        addr = fifo_addr;
                    end
                end
            end
            flb_pkg::REQ_CLEAR: begin
                n_wi   = '0;
                n_held = '0;
            end
            default: begin
            end
        endcase
    end

    // Broadcast to the lanes.
    always_comb begin
        lane_ctl.wr     = wr;
        lane_ctl.rd     = rd;
        lane_ctl.row    = addr[flb_pkg::IDX_W-1:flb_pkg::LANE_W];
        lane_ctl.offset = addr[flb_pkg::LANE_W-1:0];
        lane_ctl.mask   = flb_pkg::LANE_W'(size - flb_pkg::SIZE_W'(1));
        lane_ctl.stack  = r_stack;
    end

    for (genvar g = 0; g < flb_pkg::LANES; g++) begin : g_lane
        flb_lane u_lane (
            .i_clk        (i_clk),
            .i_lane       (flb_pkg::LANE_W'(g)),
            .i_ctl        (lane_ctl),
            .i_push_value (i_req.push_value),
            .o_rd         (lane_rd[g])
        );
    end

    flb_merge u_merge (
        .i_rd    (lane_rd),
        .o_value (merged)
    );

    // Control state: configuration, pointers and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack     <= 1'b0;
            r_log       <= '0;
            r_wi        <= '0;
            r_held      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    flb_pkg::CFG_STACK_MODE: begin
                        r_stack <= i_cfg_data[0];
                        r_wi    <= '0;
                        r_held  <= '0;
                    end
                    flb_pkg::CFG_VALUE_LOG: begin
                        r_log  <= i_cfg_data[flb_pkg::LOG_W-1:0];
                        r_wi   <= '0;
                        r_held <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (acc) begin
                r_wi   <= n_wi;
                r_held <= n_held;
            end

            if (acc) begin
                r_busy      <= rd;
                r_out_valid <= !rd;
            end else if (r_busy) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; pop data is taken from the merge in the cycle after the lane read.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pop_value <= '0;
            r_status    <= status;
            r_fill      <= flb_pkg::FILL_OUT_W'(n_held);
        end else if (r_busy) begin
            r_pop_value <= merged;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.pop_value  = r_pop_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.fill_bytes = r_fill;

endmodule

`default_nettype wire

### rtl/flb_ram.sv
// ----------------------------------------------------------------------------
// flb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module flb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/flb_lane.sv
// ----------------------------------------------------------------------------
// flb_lane: one byte lane of the buffer
// Holds every byte whose address has this lane's low bits, picks its byte
// of a pushed value and tags the byte it reads with its place in the value.
// ----------------------------------------------------------------------------
`default_nettype none

module flb_lane (
    input  wire logic                           i_clk,
    input  wire logic [flb_pkg::LANE_W-1:0]     i_lane,
    input  wire flb_pkg::t_lane_ctl             i_ctl,
    input  wire logic [flb_pkg::VALUE_W-1:0]    i_push_value,
    output flb_pkg::t_lane_rd                   o_rd
);

    logic [flb_pkg::LANE_W-1:0] diff;
    logic                       active;
    logic [flb_pkg::LANE_W-1:0] pos;
    logic [flb_pkg::BYTE_W-1:0] wdata;
    logic [flb_pkg::BYTE_W-1:0] rdata;
    logic                       r_act;
    logic [flb_pkg::LANE_W-1:0] r_pos;

    // A value is aligned to its width, so it covers lanes offset..offset+mask.
    // In stack mode the bytes lie in reverse order across those lanes.
    always_comb begin
        diff   = i_lane - i_ctl.offset;
        active = (diff <= i_ctl.mask);
        pos    = i_ctl.stack ? (i_ctl.mask - diff) : diff;
        wdata  = i_push_value[pos*flb_pkg::BYTE_W +: flb_pkg::BYTE_W];
    end

    flb_ram #(
        .WIDTH (flb_pkg::BYTE_W),
        .DEPTH (flb_pkg::ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr && active),
        .i_waddr (i_ctl.row),
        .i_wdata (wdata),
        .i_re    (i_ctl.rd && active),
        .i_raddr (i_ctl.row),
        .o_rdata (rdata)
    );

    // Remember which value byte the pending read belongs to.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_act <= active;
            r_pos <= pos;
        end
    end

    assign o_rd = '{act: r_act, pos: r_pos, data: rdata};

endmodule

`default_nettype wire

### rtl/flb_merge.sv
// ----------------------------------------------------------------------------
// flb_merge: lane merge for popped values
// Places each active lane's byte at its position in the value word.
// ----------------------------------------------------------------------------
`default_nettype none

module flb_merge (
    input  wire flb_pkg::t_lane_rd            i_rd [flb_pkg::LANES],
    output logic [flb_pkg::VALUE_W-1:0]       o_value
);

    // Each byte of the value comes from at most one lane; unused bytes stay zero.
    always_comb begin
        o_value = '0;
        for (int b = 0; b < flb_pkg::LANES; b++) begin
            for (int l = 0; l < flb_pkg::LANES; l++) begin
                if (i_rd[l].act && (i_rd[l].pos == flb_pkg::LANE_W'(b))) begin
                    o_value[b*flb_pkg::BYTE_W +: flb_pkg::BYTE_W] =
                        o_value[b*flb_pkg::BYTE_W +: flb_pkg::BYTE_W] | i_rd[l].data;
                end
            end
        end
    end

endmodule

`default_nettype wire
